// ===== rtl/core/cffd_pkg.sv =====
// ----------------------------------------------------------------------------
// cffd_pkg
// Shared types, constants and lookup functions of the checked frame field
// decoder: frame geometry, status codes, queue entry layout, field tables.
// ----------------------------------------------------------------------------
package cffd_pkg;

   localparam int FRAME_LENGTH = 16;
   localparam int CNT_W        = $clog2(FRAME_LENGTH + 2);
   localparam int IDX_W        = $clog2(FRAME_LENGTH);
   localparam int DECODE_BYTES = 14;
   localparam int SPAN         = (FRAME_LENGTH > DECODE_BYTES) ? FRAME_LENGTH : DECODE_BYTES;
   localparam int POS_W        = $clog2(DECODE_BYTES);
   localparam int QUEUE_DEPTH  = 2;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int EMIT_W       = 4;
   localparam int FIELD_ID_W   = 5;

   localparam int CONTROL_FIELDS = 15;
   localparam int STATUS_FIELDS  = 10;

   typedef logic [7:0] byte_type;

   localparam byte_type HDR_CONTROL_A = 8'hD2;
   localparam byte_type HDR_CONTROL_B = 8'hCC;
   localparam byte_type HDR_STATUS    = 8'hDD;
   localparam byte_type SUM_BIAS      = 8'(256 - (FRAME_LENGTH - 2));

   localparam int DIV20_MUL   = 205;
   localparam int DIV20_SHIFT = 12;

   typedef enum logic [2:0] {
      ST_CONTROL = 3'd0,
      ST_STATUS  = 3'd1,
      ST_BAD_LEN = 3'd2,
      ST_BAD_SUM = 3'd3,
      ST_BAD_HDR = 3'd4
   } frame_status_type;

   typedef struct packed {
      frame_status_type              status;
      logic                          complemented;
      byte_type [DECODE_BYTES-1:0]   data;
   } frame_entry_type;

   function automatic logic [FIELD_ID_W-1:0] status_field_id(input logic [EMIT_W-1:0] idx);
      logic [FIELD_ID_W-1:0] id;
      case (idx)
         4'd0:    id = 5'd15;
         4'd1:    id = 5'd16;
         4'd2:    id = 5'd17;
         4'd3:    id = 5'd18;
         4'd4:    id = 5'd19;
         4'd5:    id = 5'd20;
         4'd6:    id = 5'd21;
         4'd7:    id = 5'd22;
         4'd8:    id = 5'd13;
         4'd9:    id = 5'd14;
         default: id = 5'd0;
      endcase
      return id;
   endfunction

   function automatic logic [POS_W-1:0] status_field_pos(input logic [EMIT_W-1:0] idx);
      logic [POS_W-1:0] pos;
      case (idx)
         4'd0:    pos = 4'd1;
         4'd1:    pos = 4'd2;
         4'd2:    pos = 4'd3;
         4'd3:    pos = 4'd4;
         4'd4:    pos = 4'd5;
         4'd5:    pos = 4'd7;
         4'd6:    pos = 4'd10;
         4'd7:    pos = 4'd11;
         4'd8:    pos = 4'd12;
         4'd9:    pos = 4'd13;
         default: pos = 4'd0;
      endcase
      return pos;
   endfunction

endpackage

// ===== rtl/core/cffd_front.sv =====
// ----------------------------------------------------------------------------
// cffd_front
// Byte capture and frame check: stores bytes, keeps the running sum, and on
// the end byte checks length and checksum and emits one classified entry.
// ----------------------------------------------------------------------------
module cffd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  cffd_pkg::byte_type       rx_byte,
   input  logic                     frame_end,
   output logic                     entry_push,
   output cffd_pkg::frame_entry_type entry
);
   import cffd_pkg::*;

   byte_type           store_ff [FRAME_LENGTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   byte_type           sum_ff, sum_in, sum_new;
   byte_type           cur [DECODE_BYTES];
   byte_type [DECODE_BYTES-1:0] raw, fixed;
   logic               len_ok, raw_ok, comp_ok, use_comp;

   for (genvar g = 0; g < DECODE_BYTES; g++) begin : g_cur
      if (g < FRAME_LENGTH) begin : g_live
         assign cur[g] = (count_ff == CNT_W'(g)) ? rx_byte : store_ff[g];
      end else begin : g_zero
         assign cur[g] = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < DECODE_BYTES; i++) begin
         raw[i]   = cur[i];
         fixed[i] = ~cur[i];
      end
   end

   always_comb begin
      sum_new = sum_ff;
      if (count_ff != '0 && count_ff <= CNT_W'(FRAME_LENGTH - 2)) begin
         sum_new = sum_ff + rx_byte;
      end
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         count_in = (count_ff <= CNT_W'(FRAME_LENGTH)) ? count_ff + 1'b1 : count_ff;
         sum_in   = sum_new;
         if (frame_end) begin
            count_in = '0;
            sum_in   = '0;
         end
      end
   end

   always_comb begin
      len_ok   = (count_ff == CNT_W'(FRAME_LENGTH - 1));
      raw_ok   = (sum_new == rx_byte);
      comp_ok  = ((SUM_BIAS - sum_new) == ~rx_byte);
      use_comp = !raw_ok && comp_ok;
      entry.complemented = 1'b0;
      entry.data         = raw;
      if (!len_ok) begin
         entry.status = ST_BAD_LEN;
         entry.data   = '0;
      end else if (!raw_ok && !comp_ok) begin
         entry.status = ST_BAD_SUM;
      end else begin
         entry.complemented = use_comp;
         if (use_comp) begin
            entry.data = fixed;
         end
         if (entry.data[0] == HDR_CONTROL_A || entry.data[0] == HDR_CONTROL_B) begin
            entry.status = ST_CONTROL;
         end else if (entry.data[0] == HDR_STATUS) begin
            entry.status = ST_STATUS;
         end else begin
            entry.status = ST_BAD_HDR;
         end
      end
      entry_push = accept && frame_end;
   end

   always_ff @(posedge clock) begin
      if (accept && count_ff < CNT_W'(FRAME_LENGTH)) begin
         store_ff[count_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ===== rtl/core/cffd_queue.sv =====
// ----------------------------------------------------------------------------
// cffd_queue
// Short queue of classified frames between the capture and emit parts.
// ----------------------------------------------------------------------------
module cffd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cffd_pkg::frame_entry_type entry_wr,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output cffd_pkg::frame_entry_type head
);
   import cffd_pkg::*;

   frame_entry_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/cffd_back.sv =====
// ----------------------------------------------------------------------------
// cffd_back
// Field emitter: walks the fields of the queued frame at the head into a
// registered result stage, one per cycle while that stage is free or popped.
// ----------------------------------------------------------------------------
module cffd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  cffd_pkg::frame_entry_type head,
   output logic                      head_pop,
   output logic                      out_valid,
   input  logic                      out_pop,
   output logic [2:0]                frame_status,
   output logic                      complemented,
   output logic [7:0]                header,
   output logic [4:0]                field_id,
   output logic [7:0]                field_value,
   output logic                      last
);
   import cffd_pkg::*;

   logic [EMIT_W-1:0]     emit_ff, emit_in;
   logic                  valid_ff, valid_in;
   logic [2:0]            status_ff;
   logic                  comp_ff;
   byte_type              header_ff;
   logic [FIELD_ID_W-1:0] id_ff, id_new;
   byte_type              value_ff, value_new;
   logic                  last_ff, last_new;
   logic [EMIT_W-1:0]     n_fields;
   logic [15:0]           div_prod;
   byte_type              b7;
   logic                  load;

   assign div_prod = 16'(head.data[6]) * 16'(DIV20_MUL);
   assign b7       = head.data[7];

   always_comb begin
      case (head.status)
         ST_CONTROL: n_fields = EMIT_W'(CONTROL_FIELDS);
         ST_STATUS:  n_fields = EMIT_W'(STATUS_FIELDS);
         default:    n_fields = EMIT_W'(1);
      endcase
      last_new  = (emit_ff == n_fields - 1'b1);
      id_new    = '0;
      value_new = '0;
      case (head.status)
         ST_CONTROL: begin
            id_new = FIELD_ID_W'(emit_ff);
            case (emit_ff)
               4'd0:    value_new = head.data[2];
               4'd1:    value_new = head.data[3];
               4'd2:    value_new = head.data[4];
               4'd3:    value_new = head.data[5];
               4'd4:    value_new = 8'(div_prod >> DIV20_SHIFT);
               4'd5:    value_new = {7'd0, b7[6]};
               4'd6:    value_new = {7'd0, b7[3]};
               4'd7:    value_new = {6'd0, b7[2:1]};
               4'd8:    value_new = {7'd0, b7[5]};
               4'd9:    value_new = {7'd0, b7[7]};
               4'd10:   value_new = head.data[9];
               4'd11:   value_new = head.data[10];
               4'd12:   value_new = head.data[11];
               4'd13:   value_new = head.data[12];
               4'd14:   value_new = head.data[13];
               default: value_new = '0;
            endcase
         end
         ST_STATUS: begin
            id_new    = status_field_id(emit_ff);
            value_new = head.data[status_field_pos(emit_ff)];
         end
         default: begin
            id_new    = '0;
            value_new = '0;
         end
      endcase
   end

   always_comb begin
      load     = head_valid && (!valid_ff || out_pop);
      head_pop = load && last_new;
      valid_in = valid_ff;
      emit_in  = emit_ff;
      if (out_pop) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         emit_in  = last_new ? '0 : emit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= head.status;
         comp_ff   <= head.complemented;
         header_ff <= head.data[0];
         id_ff     <= id_new;
         value_ff  <= value_new;
         last_ff   <= last_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         emit_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         emit_ff  <= emit_in;
      end
   end

   assign out_valid    = valid_ff;
   assign frame_status = status_ff;
   assign complemented = comp_ff;
   assign header       = header_ff;
   assign field_id     = id_ff;
   assign field_value  = value_ff;
   assign last         = last_ff;

endmodule

// ===== rtl/core/checked_frame_field_decoder_top.sv =====
// ----------------------------------------------------------------------------
// checked_frame_field_decoder_top
// Frame byte receiver, checker and field decoder for a heat-pump link.
//
// Input queue: req_rx_byte and req_frame_end are taken when req_push is high
// and req_full is low, one byte per cycle. req_frame_end marks the last byte.
// Result queue: while rsp_empty is low the oldest result sits on the rsp_
// ports; rsp_pop takes it. Results of one frame end with rsp_last high.
// A control frame yields 15 results, a status frame 10, any failed frame one
// error result (bad length, bad checksum or unknown header).
// Each frame passes the frame queue, then the registered result stage; its
// results follow one per cycle while rsp_pop stays high.
// Throughput: one byte per cycle on input; results leave one per cycle while
// rsp_pop is high, from a single registered emit stage. Two finished frames
// wait in a queue between capture and emit; req_full rises while both slots
// are taken. A stalled receiver holds the current result and fills the frame
// queue; byte capture continues until then.
// Reset clears byte count, running sum, queue and result stage; stored frame
// bytes are not cleared.
// ----------------------------------------------------------------------------
module checked_frame_field_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_frame_status,
   output logic       rsp_complemented,
   output logic [7:0] rsp_header,
   output logic [4:0] rsp_field_id,
   output logic [7:0] rsp_field_value,
   output logic       rsp_last
);
   import cffd_pkg::*;

   logic            accept;
   logic            entry_push;
   frame_entry_type entry;
   logic            q_full;
   logic            head_valid;
   frame_entry_type head;
   logic            head_pop;
   logic            out_valid;
   logic            out_pop;

   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign rsp_empty = !out_valid;
   assign out_pop   = rsp_pop && out_valid;

   cffd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .frame_end  (req_frame_end),
      .entry_push (entry_push),
      .entry      (entry)
   );

   cffd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_push),
      .entry_wr   (entry),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   cffd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .out_valid    (out_valid),
      .out_pop      (out_pop),
      .frame_status (rsp_frame_status),
      .complemented (rsp_complemented),
      .header       (rsp_header),
      .field_id     (rsp_field_id),
      .field_value  (rsp_field_value),
      .last         (rsp_last)
   );

endmodule

// ===== rtl/core/cffd_checker.sv =====
// ----------------------------------------------------------------------------
// cffd_checker
// Port-level checks of the frame field decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cffd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic [7:0] req_rx_byte,
   input logic       req_frame_end,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [2:0] rsp_frame_status,
   input logic       rsp_complemented,
   input logic [7:0] rsp_header,
   input logic [4:0] rsp_field_id,
   input logic [7:0] rsp_field_value,
   input logic       rsp_last
);
   import cffd_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_frame_status == ST_BAD_LEN || rsp_frame_status == ST_BAD_SUM
                      || rsp_frame_status == ST_BAD_HDR))
      |-> rsp_last && rsp_field_id == '0 && rsp_field_value == '0)
      else $error("error result is not a lone zero result");

   a_control_header: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_status == ST_CONTROL)
      |-> (rsp_header == HDR_CONTROL_A || rsp_header == HDR_CONTROL_B))
      else $error("control result with wrong header");

   a_status_header: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_status == ST_STATUS) |-> rsp_header == HDR_STATUS)
      else $error("status result with wrong header");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_field_id)
      && $stable(rsp_field_value) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind checked_frame_field_decoder_top cffd_checker u_cffd_checker (.*);
